// ===== rtl/dtq_pkg.sv =====
package dtq_pkg;

    localparam int TIME_W      = 48;
    localparam int HANDLE_W    = 16;
    localparam int TAG_W       = 16;
    localparam int DELAY_W     = 32;
    localparam int REMOVED_W   = 5;
    localparam int MAX_RESULTS = 16;
    localparam int EMIT_W      = 5;
    localparam int MAX_REMOVED = 31;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_ADD_OK   = 2'd0,
        ST_ADD_FULL = 2'd1,
        ST_CANCEL   = 2'd2,
        ST_EXPIRED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    tag;
    } entry_t;

endpackage

// ===== rtl/dtq_store.sv =====
module dtq_store #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH)-1:0]          wr_addr,
    input  dtq_pkg::entry_t                   wr_data,
    input  logic [$clog2(DEPTH)-1:0]          rd_addr,
    output dtq_pkg::entry_t                   rd_data
);

    dtq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/deadline_task_queue.sv =====
// deadline-sorted task queue, one 48-bit comparator walked over a circular entry store
// add shifts entries up, cancel packs survivors, full add skips scans; replies wait on output
// tick: clock advances on acceptance; expired entries go out one a cycle while output is free
// throughput: one request at a time; store port, comparator: one entry a cycle unless stalled
// reset: queue empty, clock at zero, store contents left unknown
module deadline_task_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] task_handle,
    input  logic [15:0] task_tag,
    input  logic [31:0] delay_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] out_handle,
    output logic [15:0] out_tag,
    output logic [4:0]  removed_count,
    output logic        last
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TW    = dtq_pkg::TIME_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_PUT,
        S_CAN_SCAN,
        S_TICK_CHK,
        S_TICK_NEXT,
        S_RESP
    } state_t;

    state_t                       state_reg, state_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [TW-1:0]                time_reg, time_next;
    logic [TW-1:0]                dl_reg, dl_next;
    logic [15:0]                  handle_reg, handle_next;
    logic [15:0]                  tag_reg, tag_next;
    logic [CNT_W-1:0]             k_reg, k_next;
    logic [CNT_W-1:0]             w_reg, w_next;
    logic [dtq_pkg::EMIT_W-1:0]   n_reg, n_next;
    dtq_pkg::entry_t              pend_reg, pend_next;
    dtq_pkg::status_t             resp_status_reg, resp_status_next;
    logic [4:0]                   resp_removed_reg, resp_removed_next;

    logic                         out_valid_reg, out_valid_next;
    dtq_pkg::status_t             status_reg, status_next;
    logic [15:0]                  out_handle_reg, out_handle_next;
    logic [15:0]                  out_tag_reg, out_tag_next;
    logic [4:0]                   removed_count_reg, removed_count_next;
    logic                         last_reg, last_next;

    logic                         wr_en;
    logic [IDX_W-1:0]             wr_k;
    logic [IDX_W-1:0]             wr_addr;
    dtq_pkg::entry_t              wr_data;
    logic [IDX_W-1:0]             rd_k;
    logic [IDX_W-1:0]             rd_addr;
    dtq_pkg::entry_t              rd_data;

    logic [TW-1:0]                cmp_a;
    logic [TW-1:0]                cmp_b;
    logic                         cmp_lt;
    logic                         out_free;
    logic                         accept;
    logic                         keep;
    logic                         due_more;
    logic [CNT_W-1:0]             w_after;
    logic [CNT_W-1:0]             removed_raw;
    logic [CNT_W+4:0]             removed_ext;
    dtq_pkg::entry_t              new_entry;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] k);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, k};
        if (sum >= (IDX_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [dtq_pkg::EMIT_W-1:0] dl_emit_max();
        return dtq_pkg::EMIT_W'(dtq_pkg::MAX_RESULTS);
    endfunction

    dtq_store #(
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_addr = phys(head_reg, rd_k);
    assign wr_addr = phys(head_reg, wr_k);

    // shared comparator: add scan tests stored < new, tick tests clock < stored
    assign cmp_a  = (state_reg == S_ADD_SCAN) ? rd_data.deadline : time_reg;
    assign cmp_b  = (state_reg == S_ADD_SCAN) ? dl_reg : rd_data.deadline;
    assign cmp_lt = cmp_a < cmp_b;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign keep      = (rd_data.tag != tag_reg);
    assign w_after   = w_reg + CNT_W'(keep);
    assign removed_raw = count_reg - w_after;
    assign removed_ext = (CNT_W+5)'(removed_raw);
    assign due_more  = (count_reg != '0) && !cmp_lt
                       && (n_reg < dl_emit_max());
    assign new_entry = '{deadline: dl_reg, handle: handle_reg, tag: tag_reg};

    always_comb
    begin
        state_next         = state_reg;
        head_next          = head_reg;
        count_next         = count_reg;
        time_next          = time_reg;
        dl_next            = dl_reg;
        handle_next        = handle_reg;
        tag_next           = tag_reg;
        k_next             = k_reg;
        w_next             = w_reg;
        n_next             = n_reg;
        pend_next          = pend_reg;
        resp_status_next   = resp_status_reg;
        resp_removed_next  = resp_removed_reg;
        out_valid_next     = out_valid_reg;
        status_next        = status_reg;
        out_handle_next    = out_handle_reg;
        out_tag_next       = out_tag_reg;
        removed_count_next = removed_count_reg;
        last_next          = last_reg;
        wr_en              = 1'b0;
        wr_k               = k_reg[IDX_W-1:0];
        wr_data            = new_entry;
        rd_k               = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        dtq_pkg::REQ_ADD:
                        begin
                            dl_next     = time_reg + TW'(delay_ms);
                            handle_next = task_handle;
                            tag_next    = task_tag;
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                resp_status_next  = dtq_pkg::ST_ADD_FULL;
                                resp_removed_next = '0;
                                state_next        = S_RESP;
                            end
                            else if (count_reg == '0)
                            begin
                                k_next     = '0;
                                state_next = S_ADD_PUT;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                rd_k       = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_ADD_SCAN;
                            end
                        end
                        dtq_pkg::REQ_CANCEL:
                        begin
                            tag_next = task_tag;
                            k_next   = '0;
                            w_next   = '0;
                            if (count_reg == '0)
                            begin
                                resp_status_next  = dtq_pkg::ST_CANCEL;
                                resp_removed_next = '0;
                                state_next        = S_RESP;
                            end
                            else
                            begin
                                state_next = S_CAN_SCAN;
                            end
                        end
                        dtq_pkg::REQ_TICK:
                        begin
                            time_next = time_reg + TW'(1);
                            n_next    = '0;
                            if (count_reg != '0)
                            begin
                                state_next = S_TICK_CHK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_ADD_SCAN:
            begin
                // rd_data holds logical entry k-1
                wr_en = 1'b1;
                if (!cmp_lt)
                begin
                    wr_data = rd_data;
                    k_next  = k_reg - CNT_W'(1);
                    rd_k    = IDX_W'(k_reg - CNT_W'(2));
                    if (k_reg == CNT_W'(1))
                    begin
                        state_next = S_ADD_PUT;
                    end
                end
                else
                begin
                    count_next        = count_reg + CNT_W'(1);
                    resp_status_next  = dtq_pkg::ST_ADD_OK;
                    resp_removed_next = '0;
                    state_next        = S_RESP;
                end
            end

            S_ADD_PUT:
            begin
                wr_en             = 1'b1;
                count_next        = count_reg + CNT_W'(1);
                resp_status_next  = dtq_pkg::ST_ADD_OK;
                resp_removed_next = '0;
                state_next        = S_RESP;
            end

            S_CAN_SCAN:
            begin
                // rd_data holds logical entry k, survivors packed down to w
                wr_k    = w_reg[IDX_W-1:0];
                wr_data = rd_data;
                wr_en   = keep;
                w_next  = w_after;
                if (k_reg + CNT_W'(1) == count_reg)
                begin
                    count_next       = w_after;
                    resp_status_next = dtq_pkg::ST_CANCEL;
                    if (removed_ext > (CNT_W+5)'(dtq_pkg::MAX_REMOVED))
                    begin
                        resp_removed_next = 5'(dtq_pkg::MAX_REMOVED);
                    end
                    else
                    begin
                        resp_removed_next = 5'(removed_raw);
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                    rd_k   = IDX_W'(k_reg + CNT_W'(1));
                end
            end

            S_TICK_CHK:
            begin
                if (!cmp_lt)
                begin
                    pend_next  = rd_data;
                    head_next  = phys(head_reg, IDX_W'(1));
                    count_next = count_reg - CNT_W'(1);
                    n_next     = dtq_pkg::EMIT_W'(1);
                    rd_k       = IDX_W'(1);
                    state_next = S_TICK_NEXT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_TICK_NEXT:
            begin
                // front entry decides the last flag of the held transaction
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = dtq_pkg::ST_EXPIRED;
                    out_handle_next    = pend_reg.handle;
                    out_tag_next       = pend_reg.tag;
                    removed_count_next = '0;
                    last_next          = !due_more;
                    if (due_more)
                    begin
                        pend_next  = rd_data;
                        head_next  = phys(head_reg, IDX_W'(1));
                        count_next = count_reg - CNT_W'(1);
                        n_next     = n_reg + dtq_pkg::EMIT_W'(1);
                        rd_k       = IDX_W'(1);
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = resp_status_reg;
                    out_handle_next    = '0;
                    out_tag_next       = '0;
                    removed_count_next = resp_removed_reg;
                    last_next          = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            head_reg          <= '0;
            count_reg         <= '0;
            time_reg          <= '0;
            out_valid_reg     <= 1'b0;
            dl_reg            <= '0;
            handle_reg        <= '0;
            tag_reg           <= '0;
            k_reg             <= '0;
            w_reg             <= '0;
            n_reg             <= '0;
            pend_reg          <= '0;
            resp_status_reg   <= dtq_pkg::ST_ADD_OK;
            resp_removed_reg  <= '0;
            status_reg        <= dtq_pkg::ST_ADD_OK;
            out_handle_reg    <= '0;
            out_tag_reg       <= '0;
            removed_count_reg <= '0;
            last_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            head_reg          <= head_next;
            count_reg         <= count_next;
            time_reg          <= time_next;
            out_valid_reg     <= out_valid_next;
            dl_reg            <= dl_next;
            handle_reg        <= handle_next;
            tag_reg           <= tag_next;
            k_reg             <= k_next;
            w_reg             <= w_next;
            n_reg             <= n_next;
            pend_reg          <= pend_next;
            resp_status_reg   <= resp_status_next;
            resp_removed_reg  <= resp_removed_next;
            status_reg        <= status_next;
            out_handle_reg    <= out_handle_next;
            out_tag_reg       <= out_tag_next;
            removed_count_reg <= removed_count_next;
            last_reg          <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_handle    = out_handle_reg;
    assign out_tag       = out_tag_reg;
    assign removed_count = removed_count_reg;
    assign last          = last_reg;

endmodule
